// File: src/sdi_pkg.sv
// Package for the strict decimal to integer converter.
// Holds shared types, codes and constants; no dependencies.
`timescale 1ns / 1ps

package sdi_pkg;

  localparam int DefaultAccWidth = 64;
  localparam int CharWidth       = 8;
  localparam int ValueWidth      = 64;
  localparam int BaseWidth       = 6;
  localparam int CfgIndexWidth   = 2;
  localparam int CfgDataWidth    = 6;

  localparam logic [BaseWidth-1:0] BaseDecimal = 6'd10;

  localparam logic [CharWidth-1:0] ChNul   = 8'h00;
  localparam logic [CharWidth-1:0] ChZero  = 8'h30;
  localparam logic [CharWidth-1:0] ChNine  = 8'h39;
  localparam logic [CharWidth-1:0] ChMinus = 8'h2d;
  localparam logic [CharWidth-1:0] ChPlus  = 8'h2b;
  localparam logic [CharWidth-1:0] ChSpace = 8'h20;
  localparam logic [CharWidth-1:0] ChTab   = 8'h09;
  localparam logic [CharWidth-1:0] ChCr    = 8'h0d;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_SIGNED_MODE = 2'd0,
    CFG_NARROW_MODE = 2'd1,
    CFG_NUMBER_BASE = 2'd2
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_TRAIL  = 2'd3
  } phase_e;

  typedef struct packed {
    logic                 signed_mode;
    logic                 narrow_mode;
    logic [BaseWidth-1:0] number_base;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [CharWidth-1:0] ch;
  } in_item_t;

  typedef struct packed {
    logic                  valid;
    logic [ValueWidth-1:0] value;
    status_e               status;
  } result_t;

endpackage

// File: src/strict_decimal_to_integer.sv
// Top level of the strict decimal string to integer converter.
// Depends on sdi_pkg, sdi_in_stage, sdi_parser, sdi_out_stage.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------
//   input   | in_valid_i / in_stall_o    | ch_i[7:0]
//   output  | out_valid_o / out_stall_i  | value_o[63:0], status_o[1:0]
//   config  | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// One character per cycle while no NUL waits: input register, one step (x10, add,
// limit compare), result register. A NUL's result is registered when the NUL is taken.
// Only a NUL waits when the result register is full and stalled.
// Reset clears the parse state, the handshake flags and the config registers
// (signed mode, full range, base 10). No clearing pass.
`timescale 1ns / 1ps

module strict_decimal_to_integer #(
  parameter int AccWidth = sdi_pkg::DefaultAccWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sdi_pkg::CharWidth-1:0]     ch_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sdi_pkg::ValueWidth-1:0]    value_o,
  output logic [1:0]                        status_o,
  input  logic                              cfg_we_i,
  input  logic [sdi_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [sdi_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  sdi_pkg::cfg_t     cfg_q, cfg_d;
  sdi_pkg::in_item_t item;
  sdi_pkg::result_t  result;
  logic              take;
  logic              out_free;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        sdi_pkg::CFG_SIGNED_MODE: cfg_d.signed_mode = cfg_data_i[0];
        sdi_pkg::CFG_NARROW_MODE: cfg_d.narrow_mode = cfg_data_i[0];
        sdi_pkg::CFG_NUMBER_BASE: cfg_d.number_base = cfg_data_i[sdi_pkg::BaseWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signed_mode <= 1'b1;
      cfg_q.narrow_mode <= 1'b0;
      cfg_q.number_base <= sdi_pkg::BaseDecimal;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sdi_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .take_i     (take),
    .item_o     (item)
  );

  sdi_parser #(
    .AccWidth (AccWidth)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_i     (item),
    .out_free_i (out_free),
    .take_o     (take),
    .result_o   (result)
  );

  sdi_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

endmodule

// File: src/sdi_in_stage.sv
// Input register: holds one character item until the parser takes it.
// Depends on sdi_pkg.
`timescale 1ns / 1ps

module sdi_in_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sdi_pkg::CharWidth-1:0] ch_i,
  input  logic                          take_i,
  output sdi_pkg::in_item_t             item_o
);

  logic                          valid_q, valid_d;
  logic [sdi_pkg::CharWidth-1:0] ch_q;
  logic                          accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q <= ch_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.ch    = ch_q;

endmodule

// File: src/sdi_parser.sv
// Parse state and one-character step: sign, digit accumulation, limits, errors.
// Depends on sdi_pkg.
`timescale 1ns / 1ps

module sdi_parser #(
  parameter int AccWidth = sdi_pkg::DefaultAccWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdi_pkg::cfg_t     cfg_i,
  input  sdi_pkg::in_item_t item_i,
  input  logic              out_free_i,
  output logic              take_o,
  output sdi_pkg::result_t  result_o
);

  localparam int  ProdWidth = AccWidth + 4;
  localparam bit  NarrowCut = (AccWidth > 32);
  localparam logic [AccWidth-1:0] Half = {1'b1, {(AccWidth-1){1'b0}}};

  sdi_pkg::phase_e       phase_q, phase_d;
  sdi_pkg::status_e      err_q, err_d;
  logic [AccWidth-1:0]   mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic                  seen_q, seen_d;

  logic                  is_nul, is_digit, is_space, is_sign;
  logic [3:0]            digit;
  logic [AccWidth-1:0]   lim_full, lim_nul;
  logic [31:0]           lim32;
  logic [ProdWidth-1:0]  prod;
  logic                  over;
  logic [sdi_pkg::ValueWidth-1:0] mag_ext;

  assign is_nul   = (item_i.ch == sdi_pkg::ChNul);
  assign is_digit = (item_i.ch >= sdi_pkg::ChZero) && (item_i.ch <= sdi_pkg::ChNine);
  assign is_space = (item_i.ch == sdi_pkg::ChSpace) ||
                    ((item_i.ch >= sdi_pkg::ChTab) && (item_i.ch <= sdi_pkg::ChCr));
  assign is_sign  = (item_i.ch == sdi_pkg::ChMinus) || (item_i.ch == sdi_pkg::ChPlus);
  assign digit    = 4'(item_i.ch - sdi_pkg::ChZero);

  // a NUL needs a free result slot, other characters always go through
  assign take_o = item_i.valid && (!is_nul || out_free_i);

  always_comb begin
    if (!cfg_i.signed_mode) begin
      lim_full = '1;
      lim32    = 32'hffff_ffff;
    end else if (neg_q) begin
      lim_full = Half;
      lim32    = 32'h8000_0000;
    end else begin
      lim_full = Half - AccWidth'(1);
      lim32    = 32'h7fff_ffff;
    end
    lim_nul = (cfg_i.narrow_mode && NarrowCut) ? AccWidth'(lim32) : lim_full;
  end

  // mag*10 + d, exact; over-limit here matches the divided compare
  assign prod = {mag_q, 3'b000} + {2'b00, mag_q, 1'b0} + ProdWidth'(digit);
  assign over = prod > {4'b0000, lim_full};

  assign mag_ext = sdi_pkg::ValueWidth'(mag_q);

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    seen_d  = seen_q;

    result_o.valid  = take_o && is_nul;
    result_o.value  = '0;
    result_o.status = err_q;

    if (err_q == sdi_pkg::ST_OK) begin
      if (cfg_i.number_base != sdi_pkg::BaseDecimal || !seen_q) begin
        result_o.status = sdi_pkg::ST_INVALID;
      end else if (mag_q > lim_nul) begin
        result_o.status = sdi_pkg::ST_RANGE;
      end else begin
        result_o.value = neg_q ? (sdi_pkg::ValueWidth'(0) - mag_ext) : mag_ext;
      end
    end

    if (take_o) begin
      if (is_nul) begin
        phase_d = sdi_pkg::PH_LEAD;
        err_d   = sdi_pkg::ST_OK;
        mag_d   = '0;
        neg_d   = 1'b0;
        seen_d  = 1'b0;
      end else if (err_q == sdi_pkg::ST_OK) begin
        if (is_digit) begin
          if (phase_q == sdi_pkg::PH_TRAIL) begin
            err_d = sdi_pkg::ST_INVALID;
          end else if (over) begin
            err_d = sdi_pkg::ST_RANGE;
          end else begin
            mag_d   = prod[AccWidth-1:0];
            seen_d  = 1'b1;
            phase_d = sdi_pkg::PH_DIGITS;
          end
        end else if (is_space) begin
          if (phase_q == sdi_pkg::PH_SIGN) begin
            err_d = sdi_pkg::ST_INVALID;
          end else if (phase_q == sdi_pkg::PH_DIGITS) begin
            phase_d = sdi_pkg::PH_TRAIL;
          end
        end else if (is_sign && cfg_i.signed_mode && phase_q == sdi_pkg::PH_LEAD) begin
          neg_d   = (item_i.ch == sdi_pkg::ChMinus);
          phase_d = sdi_pkg::PH_SIGN;
        end else begin
          err_d = sdi_pkg::ST_INVALID;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdi_pkg::PH_LEAD;
      err_q   <= sdi_pkg::ST_OK;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      seen_q  <= seen_d;
    end
  end

endmodule

// File: src/sdi_out_stage.sv
// Result register: holds one result item until the receiver takes it.
// Depends on sdi_pkg.
`timescale 1ns / 1ps

module sdi_out_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sdi_pkg::result_t               result_i,
  output logic                           out_free_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sdi_pkg::ValueWidth-1:0] value_o,
  output logic [1:0]                     status_o
);

  logic                           valid_q, valid_d;
  logic [sdi_pkg::ValueWidth-1:0] value_q;
  sdi_pkg::status_e               status_q;

  assign out_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (result_i.valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      value_q  <= result_i.value;
      status_q <= result_i.status;
    end
  end

  assign out_valid_o = valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule
